// File: rtl/ttqp_pkg.sv
// Shared types and constants for the timed tone queue player.
`timescale 1ns / 1ps
package ttqp_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ENQ  = 2'd1,
    KIND_TONE = 2'd2,
    KIND_MUTE = 2'd3
  } kind_e;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_GAP    = 1'b1;

  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DUR_W-1:0] GAP_RESET = 16'd20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic apply;    // commit the item to the player state
  } ttqp_cmd_t;

endpackage

// File: rtl/ttqp_regs.sv
// APB-style configuration registers: enable and gap length.
`timescale 1ns / 1ps
module ttqp_regs
  import ttqp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  output logic                    enable_o,
  output logic [DUR_W-1:0]        gap_ms_o
);

  logic             enable_q;
  logic [DUR_W-1:0] gap_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      gap_q    <= GAP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_ENABLE: enable_q <= pwdata[0];
        REG_GAP:    gap_q    <= pwdata[DUR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, enable_q};
      REG_GAP:    prdata = {{(DATA_W-DUR_W){1'b0}}, gap_q};
    endcase
  end

  assign enable_o = enable_q;
  assign gap_ms_o = gap_q;

endmodule

// File: rtl/ttqp_ctrl.sv
// Controller state machine: sequences capture, fetch and apply of one item.
`timescale 1ns / 1ps
module ttqp_ctrl
  import ttqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output ttqp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_APPLY
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_FETCH;
            busy_q  <= 1'b1;
          end
        end
        ST_FETCH: begin
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.capture = start_i && !busy_q;
  assign cmd_o.apply   = (state_q == ST_APPLY);
  assign busy_o        = busy_q;
  assign done_o        = done_q;

endmodule

// File: rtl/ttqp_dp.sv
// Datapath: note ring buffer, playback timer and result registers.
`timescale 1ns / 1ps
module ttqp_dp
  import ttqp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttqp_cmd_t         cmd_i,
  input  logic [1:0]        kind_i,
  input  logic [FREQ_W-1:0] note_freq_i,
  input  logic [DUR_W-1:0]  note_duration_i,
  input  logic              enable_i,
  input  logic [DUR_W-1:0]  gap_ms_i,
  output logic [FREQ_W-1:0] drive_freq_o,
  output logic              busy_res_o,
  output logic [CNT_W-1:0]  queue_count_o,
  output logic              accepted_o
);

  localparam int unsigned NOTE_W = FREQ_W + DUR_W;

  // Latched item
  kind_e             kind_q;
  logic [FREQ_W-1:0] in_freq_q;
  logic [DUR_W-1:0]  in_dur_q;

  // Note memory with registered read of the queue head
  logic [NOTE_W-1:0] mem [QUEUE_DEPTH];
  logic [NOTE_W-1:0] rd_data_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;

  // Player state
  logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              playing_q, playing_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [DUR_W-1:0]  wait_q, wait_d;
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic              acc_q, acc_d;

  logic [TIME_W-1:0] elapsed_inc;
  logic              wait_over;
  logic              full;
  logic [IDX_W-1:0]  wr_idx_inc;
  logic [IDX_W-1:0]  rd_idx_inc;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_e'(kind_i);
      in_freq_q <= note_freq_i;
      in_dur_q  <= note_duration_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= {in_dur_q, in_freq_q};
    end
    rd_data_q <= mem[rd_idx_q];
  end

  assign elapsed_inc = elapsed_q + TIME_W'(1);
  assign wait_over   = (elapsed_inc >= {{(TIME_W-DUR_W){1'b0}}, wait_q});
  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign wr_idx_inc  = (wr_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_q + IDX_W'(1);
  assign rd_idx_inc  = (rd_idx_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_q + IDX_W'(1);

  always_comb begin
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    count_d   = count_q;
    playing_d = playing_q;
    elapsed_d = elapsed_q;
    wait_d    = wait_q;
    freq_d    = freq_q;
    acc_d     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_idx_q;

    unique case (kind_q)
      KIND_TICK: begin
        elapsed_d = elapsed_inc;
        if (!enable_i) begin
          wr_idx_d  = '0;
          rd_idx_d  = '0;
          count_d   = '0;
          playing_d = 1'b0;
          freq_d    = '0;
        end else if (playing_q) begin
          if (wait_over) begin
            freq_d    = '0;
            playing_d = 1'b0;
            elapsed_d = '0;
            wait_d    = gap_ms_i;
          end
        end else if (wait_over && (count_q != '0)) begin
          freq_d    = rd_data_q[FREQ_W-1:0];
          wait_d    = rd_data_q[NOTE_W-1:FREQ_W];
          elapsed_d = '0;
          playing_d = 1'b1;
          rd_idx_d  = rd_idx_inc;
          count_d   = count_q - CNT_W'(1);
        end
      end
      KIND_ENQ: begin
        if (enable_i && !full) begin
          mem_we   = 1'b1;
          wr_idx_d = wr_idx_inc;
          count_d  = count_q + CNT_W'(1);
          acc_d    = 1'b1;
        end
      end
      KIND_TONE: begin
        if (enable_i) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          wr_idx_d  = IDX_W'(1);
          rd_idx_d  = '0;
          count_d   = CNT_W'(1);
          playing_d = 1'b0;
          freq_d    = '0;
          acc_d     = 1'b1;
        end
      end
      KIND_MUTE: begin
        wr_idx_d  = '0;
        rd_idx_d  = '0;
        count_d   = '0;
        playing_d = 1'b0;
        freq_d    = '0;
      end
    endcase

    if (!cmd_i.apply) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
      count_q   <= '0;
      playing_q <= 1'b0;
      elapsed_q <= '0;
      wait_q    <= '0;
      freq_q    <= '0;
      acc_q     <= 1'b0;
    end else if (cmd_i.apply) begin
      wr_idx_q  <= wr_idx_d;
      rd_idx_q  <= rd_idx_d;
      count_q   <= count_d;
      playing_q <= playing_d;
      elapsed_q <= elapsed_d;
      wait_q    <= wait_d;
      freq_q    <= freq_d;
      acc_q     <= acc_d;
    end
  end

  assign drive_freq_o  = freq_q;
  assign busy_res_o    = playing_q || (count_q != '0);
  assign queue_count_o = count_q;
  assign accepted_o    = acc_q;

endmodule

// File: rtl/timed_tone_queue_player_unit.sv
// Top level of the timed tone queue player: registers, controller and datapath.
// An accepted item is captured, the registered note memory read settles in the fetch
// state and the apply state commits it; its result then shows, with done_o high, in a
// single cycle, and busy is high in between. A new item is taken only once busy falls,
// after the fetch and apply states; a new start may coincide with done_o.
// Reset (rst_ni low, asynchronous): empty queue, silent, timer and gap wait at zero,
// enable off, gap 20 ms; the note memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module timed_tone_queue_player_unit
  import ttqp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  // Item command port
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [FREQ_W-1:0] note_freq_i,
  input  logic [DUR_W-1:0]  note_duration_i,

  // Result strobe and fields
  output logic              done_o,
  output logic [FREQ_W-1:0] drive_freq_o,
  output logic              busy_res_o,
  output logic [CNT_W-1:0]  queue_count_o,
  output logic              accepted_o,

  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  ttqp_cmd_t        cmd;
  logic             enable;
  logic [DUR_W-1:0] gap_ms;

  // Configuration registers; the user is to write them only while no transaction is in
  // flight, so the datapath sees them stable across a whole item; the block does not enforce it.
  ttqp_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .enable_o (enable),
    .gap_ms_o (gap_ms)
  );

  // Sequence each transaction: capture on accept, let the head-of-queue read
  // settle in the fetch state, then commit the state update and raise done_o.
  ttqp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Hold the note ring, the millisecond timer and the driven frequency.
  // Result fields come straight from its state registers, which only change
  // on the apply cycle, so they stay stable while done_o is high.
  ttqp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (kind_i),
    .note_freq_i     (note_freq_i),
    .note_duration_i (note_duration_i),
    .enable_i        (enable),
    .gap_ms_i        (gap_ms),
    .drive_freq_o    (drive_freq_o),
    .busy_res_o      (busy_res_o),
    .queue_count_o   (queue_count_o),
    .accepted_o      (accepted_o)
  );

endmodule

// File: rtl/ttqp_checker.sv
// Port-level checker for the timed tone queue player, bound to the top level.
`timescale 1ns / 1ps
module ttqp_checker #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic             busy_res_o,
  input logic [CNT_W-1:0] queue_count_o
);

  // Every accepted transaction yields its result strobe.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing after accepted transaction");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy still high while result is shown");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (queue_count_o <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_busy_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (queue_count_o != '0)) |-> busy_res_o)
    else $error("busy result low with notes waiting");

endmodule

bind timed_tone_queue_player_unit ttqp_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .busy_res_o    (busy_res_o),
  .queue_count_o (queue_count_o)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the timed tone queue player unit.
`timescale 1ns / 1ps
module testbench;
  import ttqp_pkg::*;

  localparam int unsigned NOTE_SLOTS  = 16;
  localparam int unsigned STALL_LIMIT = 2000;

  // One note command as the sender drives it
  typedef struct packed {
    kind_e             kind;
    logic [FREQ_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } note_cmd_t;

  // Player status expected after one command; tag holds the cycle of acceptance
  typedef struct packed {
    logic [FREQ_W-1:0] drive_freq;
    logic              busy_res;
    logic [4:0]        queue_count;
    logic              accepted;
    logic [31:0]       tag;
  } player_status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        kind_i = KIND_TICK;
  logic [FREQ_W-1:0] note_freq_i = '0;
  logic [DUR_W-1:0]  note_duration_i = '0;
  logic              done_o;
  logic [FREQ_W-1:0] drive_freq_o;
  logic              busy_res_o;
  logic [4:0]        queue_count_o;
  logic              accepted_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  timed_tone_queue_player_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .note_freq_i     (note_freq_i),
    .note_duration_i (note_duration_i),
    .done_o          (done_o),
    .drive_freq_o    (drive_freq_o),
    .busy_res_o      (busy_res_o),
    .queue_count_o   (queue_count_o),
    .accepted_o      (accepted_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // Commands waiting for the driver, and player status waiting for the monitor
  note_cmd_t      note_cmd_q[$];
  player_status_t status_q[$];

  // Shadow of the player: register copies and its own queue, timer and tone
  logic              cfg_enable = 1'b0;
  logic [DUR_W-1:0]  cfg_gap = GAP_RESET;
  logic [FREQ_W-1:0] slot_freq [NOTE_SLOTS];
  logic [DUR_W-1:0]  slot_dur  [NOTE_SLOTS];
  logic [3:0]        wr_ptr = '0;
  logic [3:0]        rd_ptr = '0;
  logic [4:0]        note_cnt = '0;
  logic              playing = 1'b0;
  logic [31:0]       now_ms = '0;
  logic [31:0]       start_ms = '0;
  logic [DUR_W-1:0]  wait_ms = '0;
  logic [FREQ_W-1:0] cur_freq = '0;

  logic [31:0] cycle_no = '0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cnt = 0;
  bit          no_idle = 1'b0;
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned notes_stored = 0;
  int unsigned notes_dropped = 0;
  int unsigned notes_played = 0;
  int unsigned settings_seen = 0;

  // Silence the player and empty its queue; the timer and pending wait survive
  task automatic stop_player();
    note_cnt = '0;
    wr_ptr   = '0;
    rd_ptr   = '0;
    playing  = 1'b0;
    cur_freq = '0;
  endtask

  // Store a note unless the queue is full; return whether it was taken
  function automatic logic push_note(input note_cmd_t cmd);
    if (note_cnt >= NOTE_SLOTS) begin
      notes_dropped++;
      return 1'b0;
    end
    slot_freq[wr_ptr] = cmd.freq;
    slot_dur[wr_ptr]  = cmd.dur;
    wr_ptr   = wr_ptr + 1'b1;
    note_cnt = note_cnt + 1'b1;
    notes_stored++;
    return 1'b1;
  endfunction

  // Apply one command to the shadow player and queue the status it leaves behind
  task automatic advance_player(input note_cmd_t cmd);
    player_status_t st;
    logic [31:0]    elapsed;
    logic           took;
    took = 1'b0;
    case (cmd.kind)
      KIND_TICK: begin
        now_ms = now_ms + 1;
        if (!cfg_enable) begin
          stop_player();
        end else begin
          // modular difference keeps working across a timer wrap
          elapsed = now_ms - start_ms;
          if (playing) begin
            if (elapsed >= {16'd0, wait_ms}) begin
              cur_freq = '0;
              playing  = 1'b0;
              start_ms = now_ms;
              wait_ms  = cfg_gap;
            end
          end else if (elapsed >= {16'd0, wait_ms} && note_cnt != 0) begin
            cur_freq = slot_freq[rd_ptr];
            wait_ms  = slot_dur[rd_ptr];
            rd_ptr   = rd_ptr + 1'b1;
            note_cnt = note_cnt - 1'b1;
            start_ms = now_ms;
            playing  = 1'b1;
            notes_played++;
          end
        end
      end
      KIND_ENQ: begin
        if (cfg_enable) took = push_note(cmd);
      end
      KIND_TONE: begin
        if (cfg_enable) begin
          stop_player();
          took = push_note(cmd);
        end
      end
      default: begin
        // mute works even while disabled
        stop_player();
      end
    endcase
    st.drive_freq  = cur_freq;
    st.busy_res    = playing || (note_cnt != 0);
    st.queue_count = note_cnt;
    st.accepted    = took;
    st.tag         = cycle_no;
    status_q.push_back(st);
  endtask

  // Mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // Driver: hand out queued commands, predict each one at the edge that takes it
  always @(posedge clk_i) begin : driver
    note_cmd_t cmd;
    logic      slot_free;
    if (rst_ni) begin
      slot_free = !start;
      if (start && !busy) begin
        cmd.kind = kind_e'(kind_i);
        cmd.freq = note_freq_i;
        cmd.dur  = note_duration_i;
        advance_player(cmd);
        hold_cnt  = pick_gap();
        slot_free = 1'b1;
      end
      // one assignment to start per edge: keep it high straight into the next command
      if (slot_free) begin
        if (hold_cnt > 0) begin
          hold_cnt--;
          start <= 1'b0;
        end else if (note_cmd_q.size() > 0) begin
          cmd = note_cmd_q.pop_front();
          kind_i          <= cmd.kind;
          note_freq_i     <= cmd.freq;
          note_duration_i <= cmd.dur;
          start           <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin : monitor
    player_status_t want;
    if (rst_ni && done_o) begin
      // a prediction made at this same edge cannot be the answer yet
      if (status_q.size() == 0 || status_q[0].tag == cycle_no) begin
        $display("%0t: unexpected result, expected none, actual freq %0d busy %0d",
                 $time, drive_freq_o, busy_res_o);
        $display("%0t: unexpected result, actual count %0d acc %0d",
                 $time, queue_count_o, accepted_o);
        errors++;
      end else begin
        want = status_q.pop_front();
        checked++;
        if (drive_freq_o !== want.drive_freq) begin
          $display("%0t: drive_freq expected %0d actual %0d", $time, want.drive_freq,
                   drive_freq_o);
          errors++;
        end
        if (busy_res_o !== want.busy_res) begin
          $display("%0t: busy_res expected %0d actual %0d", $time, want.busy_res, busy_res_o);
          errors++;
        end
        if (queue_count_o !== want.queue_count) begin
          $display("%0t: queue_count expected %0d actual %0d", $time, want.queue_count,
                   queue_count_o);
          errors++;
        end
        if (accepted_o !== want.accepted) begin
          $display("%0t: accepted expected %0d actual %0d", $time, want.accepted, accepted_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transaction on either port or the register port resets the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, status_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Register write: setup cycle, then the access cycle that commits at its closing edge
  task automatic reg_write(input logic reg_idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_ENABLE) cfg_enable = value[0];
    else cfg_gap = value[DUR_W-1:0];
  endtask

  // Hold until every command is taken and every result is back, then let the pipe drain
  task automatic settle();
    @(negedge clk_i);
    while (note_cmd_q.size() != 0 || start || status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic next_setting(input logic en, input logic [DUR_W-1:0] gap, input bit calm);
    settle();
    reg_write(REG_GAP, {16'd0, gap});
    reg_write(REG_ENABLE, {31'd0, en});
    @(negedge clk_i);
    no_idle = calm;
    settings_seen++;
  endtask

  task automatic add_cmd(input kind_e k, input logic [FREQ_W-1:0] f,
                         input logic [DUR_W-1:0] d);
    note_cmd_t cmd;
    cmd.kind = k;
    cmd.freq = f;
    cmd.dur  = d;
    note_cmd_q.push_back(cmd);
  endtask

  // Rests and the top frequency show up often, the rest is uniform
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 2) return '0;
    if (r == 2) return '1;
    return FREQ_W'($urandom);
  endfunction

  // Short notes keep the player cycling; wide ones only where the run can afford to stall
  function automatic logic [DUR_W-1:0] pick_dur(input bit wide);
    int unsigned r;
    r = $urandom_range(99);
    if (wide && r < 30) return DUR_W'($urandom);
    if (r < 65) return DUR_W'($urandom_range(0, 4));
    return DUR_W'($urandom_range(5, 30));
  endfunction

  // Queue n commands: mostly melodies (a burst of notes, then ticks to play them out)
  task automatic queue_random_run(input int unsigned n, input bit wide);
    int unsigned made;
    int unsigned r;
    int unsigned burst;
    int unsigned ticks;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // an occasional long burst overruns the queue
        burst = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
        for (int unsigned i = 0; i < burst; i++) begin
          if (i == 0 && $urandom_range(3) == 0) add_cmd(KIND_TONE, pick_freq(), pick_dur(wide));
          else add_cmd(KIND_ENQ, pick_freq(), pick_dur(wide));
        end
        ticks = $urandom_range(0, 40);
        repeat (ticks) add_cmd(KIND_TICK, FREQ_W'($urandom), DUR_W'($urandom));
        made += burst + ticks;
      end else if (r < 85) begin
        ticks = $urandom_range(1, 8);
        repeat (ticks) add_cmd(KIND_TICK, FREQ_W'($urandom), DUR_W'($urandom));
        made += ticks;
      end else if (r < 92) begin
        add_cmd(KIND_MUTE, FREQ_W'($urandom), DUR_W'($urandom));
        made++;
      end else begin
        // noise: any kind with arbitrary fields
        add_cmd(kind_e'($urandom_range(3)), FREQ_W'($urandom), pick_dur(wide));
        made++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Disabled out of reset: notes are refused, tick and mute still answer
    add_cmd(KIND_ENQ, 16'h1234, 16'd5);
    add_cmd(KIND_TONE, 16'hFFFF, 16'hFFFF);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_MUTE, '0, '0);

    // Enabled with no gap: play, rest, a cut note that keeps delaying the next one
    next_setting(1'b1, 16'd0, 1'b0);
    add_cmd(KIND_TONE, 16'hFFFF, 16'd2);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_ENQ, 16'h0000, 16'h0000);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_ENQ, 16'hAAAA, 16'hFFFF);
    add_cmd(KIND_ENQ, 16'h5555, 16'h8000);
    add_cmd(KIND_TONE, 16'h8001, 16'd1);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_MUTE, '0, '0);
    add_cmd(KIND_ENQ, 16'h00FF, 16'd3);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_TICK, '0, '0);
    add_cmd(KIND_MUTE, 16'hFFFF, 16'hFFFF);
    queue_random_run(130, 1'b0);

    next_setting(1'b1, 16'd3, 1'b0);
    queue_random_run(130, 1'b0);

    // back to back with no idle cycles
    next_setting(1'b1, 16'd1, 1'b1);
    queue_random_run(110, 1'b0);

    // disabled: ticks drain and silence the player
    next_setting(1'b0, GAP_RESET, 1'b0);
    queue_random_run(70, 1'b0);

    next_setting(1'b1, DUR_W'($urandom_range(2, 12)), 1'b0);
    queue_random_run(130, 1'b0);

    // longest gap last, since it stalls playback for the rest of the run
    next_setting(1'b1, 16'hFFFF, 1'b0);
    queue_random_run(140, 1'b1);

    settle();
    repeat (10) @(posedge clk_i);
    if (status_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, status_q.size());
      errors++;
    end

    $display("Checked %0d results across %0d register settings, gap 0 to 65535, enabled and not.",
             checked, settings_seen);
    $display("Notes stored %0d, dropped on a full queue %0d, started playing %0d.",
             notes_stored, notes_dropped, notes_played);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
